@@ sv/cnlc_pkg.sv @@
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and constants for the card number classifier
// Widths, the BCD word, the brand codes, the result record and the Luhn
// digit map.
// ----------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

    // input card number width
    localparam int CARD_W = 63;
    // decimal digits a 63-bit value can need
    localparam int FULL_DIGITS = 19;
    localparam int BCD_W = FULL_DIGITS * 4;
    // default digit limit of the digit count and sum
    localparam int MAX_DIGITS_DEF = 19;

    // binary bits converted in each double-dabble stage
    localparam int DAB_BITS = 3;
    localparam int DAB_STAGES = CARD_W / DAB_BITS;

    // digit sum tree: groups of digits summed in the first sum stage
    localparam int GRP_SIZE = 5;
    localparam int GRP_NUM = (FULL_DIGITS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_SUM_W = 6;
    localparam int SUM_W = 8;

    localparam int CNT_W = 5;

    // stream data widths, padded to whole bytes
    localparam int IN_TDATA_W = 64;
    localparam int OUT_TDATA_W = 16;

    // prefix and length constants of the brand rules
    localparam logic [3:0] DIG_3 = 4'd3;
    localparam logic [3:0] DIG_4 = 4'd4;
    localparam logic [3:0] DIG_5 = 4'd5;
    localparam logic [3:0] DIG_7 = 4'd7;
    localparam logic [3:0] DIG_1 = 4'd1;
    localparam logic [CNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [CNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [CNT_W-1:0] LEN_16 = 5'd16;

    // reciprocal of ten for sums below 180: q = (s * 205) >> 11
    localparam logic [7:0] RECIP_10 = 8'd205;
    localparam int RECIP_SHIFT = 11;
    localparam logic [3:0] TEN = 4'd10;

    typedef logic [BCD_W-1:0] t_bcd;
    typedef logic [CARD_W-1:0] t_card;

    typedef enum logic [1:0] {
        BRAND_NONE = 2'd0,
        BRAND_P34  = 2'd1,
        BRAND_P5X  = 2'd2,
        BRAND_P4   = 2'd3
    } t_brand;

    typedef struct packed {
        logic       luhn_ok;
        logic [3:0] luhn_remainder;
        logic [CNT_W-1:0] digit_count;
        t_brand     brand_code;
    } t_result;

    // Luhn weight of a digit: doubled digits fold their two decimal digits
    function automatic logic [3:0] luhn_map(input logic [3:0] d, input logic dbl);
        logic [4:0] t;
        t = {d, 1'b0};
        if (!dbl) begin
            luhn_map = d;
        end else if (t >= 5'd10) begin
            luhn_map = 4'(t - 5'd9);
        end else begin
            luhn_map = t[3:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/cnlc_dabble_stage.sv @@
// ----------------------------------------------------------------------------
// cnlc_dabble_stage: one stage of the binary to BCD converter
// Shifts DAB_BITS binary bits into the BCD word, add-3 before each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_dabble_stage (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  wire             i_valid,
    input  cnlc_pkg::t_card i_bin,
    input  cnlc_pkg::t_bcd  i_bcd,
    output logic            o_valid,
    output cnlc_pkg::t_card o_bin,
    output cnlc_pkg::t_bcd  o_bcd
);
    import cnlc_pkg::*;

    logic  r_valid;
    t_card r_bin, n_bin;
    t_bcd  r_bcd, n_bcd;

    // add-3 then shift, one binary bit per step, MSB first
    always_comb begin
        n_bin = i_bin;
        n_bcd = i_bcd;
        for (int k = 0; k < DAB_BITS; k++) begin
            for (int d = 0; d < FULL_DIGITS; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[CARD_W-1]};
            n_bin = {n_bin[CARD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;

endmodule

`default_nettype wire

@@ sv/cnlc_digit_sum.sv @@
// ----------------------------------------------------------------------------
// cnlc_digit_sum: Luhn digit sum, digit count and leading digits
// Two stages: group sums and count, then total sum and leading-digit pick.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_digit_sum #(
    parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  cnlc_pkg::t_bcd               i_bcd,
    output logic                         o_valid,
    output logic [cnlc_pkg::SUM_W-1:0]   o_sum,
    output logic [cnlc_pkg::CNT_W-1:0]   o_count,
    output logic                         o_ovf,
    output logic [3:0]                   o_lead_hi,
    output logic [3:0]                   o_lead_lo
);
    import cnlc_pkg::*;

    // stage 1 registers
    logic                 r_valid1;
    logic [GRP_SUM_W-1:0] r_grp [GRP_NUM];
    logic [GRP_SUM_W-1:0] n_grp [GRP_NUM];
    logic [CNT_W-1:0]     r_cnt1, n_cnt1;
    logic                 r_ovf1, n_ovf1;
    t_bcd                 r_bcd1;

    // stage 2 registers
    logic                 r_valid2;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_cnt2;
    logic                 r_ovf2;
    logic [3:0]           r_hi, n_hi;
    logic [3:0]           r_lo, n_lo;

    // mapped digits summed per group; odd positions are doubled
    always_comb begin
        for (int g = 0; g < GRP_NUM; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < MAX_DIGITS) begin
                    n_grp[g] = n_grp[g] + GRP_SUM_W'(luhn_map(
                        i_bcd[(g*GRP_SIZE+j)*4 +: 4], ((g * GRP_SIZE + j) % 2) == 1));
                end
            end
        end
    end

    // digit count: highest nonzero digit, saturated on overflow
    always_comb begin
        n_cnt1 = '0;
        n_ovf1 = 1'b0;
        for (int i = 0; i < FULL_DIGITS; i++) begin
            if (i < MAX_DIGITS) begin
                if (i_bcd[i*4 +: 4] != 4'd0) begin
                    n_cnt1 = CNT_W'(i + 1);
                end
            end else if (i_bcd[i*4 +: 4] != 4'd0) begin
                n_ovf1 = 1'b1;
            end
        end
        if (n_ovf1) begin
            n_cnt1 = CNT_W'(MAX_DIGITS);
        end
    end

    // total sum and leading two digits
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < GRP_NUM; g++) begin
            n_sum = n_sum + SUM_W'(r_grp[g]);
        end
        n_hi = '0;
        n_lo = '0;
        for (int i = 0; i < FULL_DIGITS; i++) begin
            if (r_cnt1 == CNT_W'(i + 1)) begin
                n_hi = r_bcd1[i*4 +: 4];
                if (i >= 1) begin
                    n_lo = r_bcd1[(i-1)*4 +: 4];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp  <= n_grp;
            r_cnt1 <= n_cnt1;
            r_ovf1 <= n_ovf1;
            r_bcd1 <= i_bcd;
            r_sum  <= n_sum;
            r_cnt2 <= r_cnt1;
            r_ovf2 <= r_ovf1;
            r_hi   <= n_hi;
            r_lo   <= n_lo;
        end
    end

    assign o_valid   = r_valid2;
    assign o_sum     = r_sum;
    assign o_count   = r_cnt2;
    assign o_ovf     = r_ovf2;
    assign o_lead_hi = r_hi;
    assign o_lead_lo = r_lo;

endmodule

`default_nettype wire

@@ sv/cnlc_classify.sv @@
// ----------------------------------------------------------------------------
// cnlc_classify: remainder modulo ten and brand selection
// One stage: reciprocal divide of the digit sum, then the prefix rules.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_classify (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [cnlc_pkg::SUM_W-1:0]    i_sum,
    input  wire [cnlc_pkg::CNT_W-1:0]    i_count,
    input  wire                          i_ovf,
    input  wire [3:0]                    i_lead_hi,
    input  wire [3:0]                    i_lead_lo,
    output logic                         o_valid,
    output cnlc_pkg::t_result            o_result
);
    import cnlc_pkg::*;

    logic            r_valid;
    t_result         r_res, n_res;
    logic [15:0]     prod;
    logic [4:0]      quot;
    logic [SUM_W-1:0] rem_full;
    logic [3:0]      rem;
    logic            p34, p5x, p4;

    always_comb begin
        // sum / 10 by reciprocal, exact for sums below 180
        prod     = 16'(i_sum) * 16'(RECIP_10);
        quot     = prod[RECIP_SHIFT +: 5];
        rem_full = i_sum - (SUM_W'(quot) * SUM_W'(TEN));
        rem      = rem_full[3:0];

        // prefix checks
        p34 = (i_count == LEN_15) && (i_lead_hi == DIG_3)
              && ((i_lead_lo == DIG_4) || (i_lead_lo == DIG_7));
        p5x = (i_count == LEN_16) && (i_lead_hi == DIG_5)
              && (i_lead_lo >= DIG_1) && (i_lead_lo <= DIG_5);
        p4  = ((i_count == LEN_13) || (i_count == LEN_16)) && (i_lead_hi == DIG_4);

        n_res.digit_count    = i_count;
        n_res.luhn_remainder = rem;
        n_res.luhn_ok        = (rem == 4'd0);
        n_res.brand_code     = BRAND_NONE;
        if (!i_ovf && rem == 4'd0) begin
            if (p34) begin
                n_res.brand_code = BRAND_P34;
            end else if (p5x) begin
                n_res.brand_code = BRAND_P5X;
            end else if (p4) begin
                n_res.brand_code = BRAND_P4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

@@ sv/cnlc_out_skid.sv @@
// ----------------------------------------------------------------------------
// cnlc_out_skid: output register with a skid entry
// Holds results for the master side; stalls the pipeline only when full.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_out_skid (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  cnlc_pkg::t_result i_result,
    input  wire               i_ready,
    output logic              o_valid,
    output cnlc_pkg::t_result o_result,
    output logic              o_full
);
    import cnlc_pkg::*;

    logic    r_m_valid, n_m_valid;
    logic    r_s_valid, n_s_valid;
    t_result r_m_data, n_m_data;
    t_result r_s_data, n_s_data;
    logic    pop;

    assign pop = r_m_valid && i_ready;

    // main register feeds the port; skid catches an item pushed during a stall
    always_comb begin
        n_m_valid = r_m_valid;
        n_s_valid = r_s_valid;
        n_m_data  = r_m_data;
        n_s_data  = r_s_data;
        if (r_s_valid) begin
            if (pop) begin
                n_m_data  = r_s_data;
                n_s_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_m_valid || pop) begin
                n_m_data  = i_result;
                n_m_valid = 1'b1;
            end else begin
                n_s_data  = i_result;
                n_s_valid = 1'b1;
            end
        end else if (pop) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            r_s_valid <= n_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_s_data <= n_s_data;
    end

    assign o_valid  = r_m_valid;
    assign o_result = r_m_data;
    assign o_full   = r_s_valid;

endmodule

`default_nettype wire

@@ sv/card_number_luhn_classifier.sv @@
// Pipeline: 21 converter stages, 2 digit-sum stages, 1 classify stage and
//   1 output register from input accept to o_m_axis_tvalid.
// Throughput: one item per cycle; the pipeline halts only while the output
//   skid entry is occupied.
// Reset: i_rst_n synchronous, active low; clears all valid bits, no data reset.
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: card number Luhn check and brand classifier
// Double-dabble binary to BCD pipeline, Luhn digit sum, brand rules.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier #(
    parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [62:0] card_number, [63] zero pad
    input  wire [cnlc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [1:0] brand_code, [6:2] digit_count, [10:7] luhn_remainder,
    // [11] luhn_ok, [15:12] zero pad
    output logic [cnlc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import cnlc_pkg::*;

    logic    en;
    logic    skid_full;

    logic    dab_valid [DAB_STAGES+1];
    t_card   dab_bin   [DAB_STAGES+1];
    t_bcd    dab_bcd   [DAB_STAGES+1];

    logic             sum_valid;
    logic [SUM_W-1:0] sum_val;
    logic [CNT_W-1:0] sum_cnt;
    logic             sum_ovf;
    logic [3:0]       lead_hi, lead_lo;

    logic    cls_valid;
    t_result cls_res;
    t_result out_res;

    // whole pipeline moves unless the skid entry holds an item
    assign en              = !skid_full;
    assign o_s_axis_tready = en;

    assign dab_valid[0] = i_s_axis_tvalid;
    assign dab_bin[0]   = i_s_axis_tdata[CARD_W-1:0];
    assign dab_bcd[0]   = '0;

    // binary to BCD converter stages
    for (genvar s = 0; s < DAB_STAGES; s++) begin : g_dab
        cnlc_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dab_valid[s]),
            .i_bin   (dab_bin[s]),
            .i_bcd   (dab_bcd[s]),
            .o_valid (dab_valid[s+1]),
            .o_bin   (dab_bin[s+1]),
            .o_bcd   (dab_bcd[s+1])
        );
    end

    cnlc_digit_sum #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (dab_valid[DAB_STAGES]),
        .i_bcd     (dab_bcd[DAB_STAGES]),
        .o_valid   (sum_valid),
        .o_sum     (sum_val),
        .o_count   (sum_cnt),
        .o_ovf     (sum_ovf),
        .o_lead_hi (lead_hi),
        .o_lead_lo (lead_lo)
    );

    cnlc_classify u_cls (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (sum_valid),
        .i_sum     (sum_val),
        .i_count   (sum_cnt),
        .i_ovf     (sum_ovf),
        .i_lead_hi (lead_hi),
        .i_lead_lo (lead_lo),
        .o_valid   (cls_valid),
        .o_result  (cls_res)
    );

    cnlc_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (en && cls_valid),
        .i_result (cls_res),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_res),
        .o_full   (skid_full)
    );

    assign o_m_axis_tdata = {4'd0, out_res.luhn_ok, out_res.luhn_remainder,
                             out_res.digit_count, out_res.brand_code};

endmodule

`default_nettype wire

@@ bench/card_number_luhn_classifier_test.sv @@
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_test: self-checking bench for the card classifier
// Streams card numbers into the block under four flow-control phases, predicts
// digit count, Luhn remainder and brand for each accepted item, and compares
// every returned item against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cnlc_pkg::*;

    localparam int DIGIT_LIMIT = MAX_DIGITS_DEF;
    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 5;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int NUM_PHASES = 4;
    // leave room after the last expected item for any stray item
    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 100000;

    typedef enum {FILL_RANDOM, FILL_VALID, FILL_BROKEN} t_fill_mode;

    typedef struct {
        t_card   card;
        t_result res;
    } t_luhn_expect;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // [62:0] card_number, [63] zero pad
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // [1:0] brand_code, [6:2] digit_count, [10:7] luhn_remainder,
    // [11] luhn_ok, [15:12] zero pad
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_card        card_q[$];
    t_luhn_expect luhn_exp_q[$];
    logic         in_taken;
    int unsigned  send_idle_pct;
    int unsigned  stall_pct;
    int unsigned  err_cnt;
    int unsigned  cycle_cnt;

    card_number_luhn_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Luhn remainder, digit count and brand of one card number
    function automatic t_result luhn_classify(input t_card card);
        logic [63:0] rest;
        int unsigned digs [DIGIT_LIMIT];
        int unsigned n_dig;
        int unsigned total;
        int unsigned d;
        int unsigned top1;
        int unsigned top2;
        int unsigned rem;
        t_result     res;
        rest = {1'b0, card};
        n_dig = 0;
        total = 0;
        top1 = 0;
        top2 = 0;
        for (int k = 0; k < DIGIT_LIMIT; k++) begin
            if (rest != 0) begin
                n_dig = k + 1;
            end
            d = int'(rest % 10);
            rest = rest / 10;
            digs[k] = d;
            // even positions from the right are doubled and folded
            if (k % 2 == 1) begin
                total += (2 * d >= 10) ? 2 * d - 9 : 2 * d;
            end else begin
                total += d;
            end
        end
        rem = total % 10;
        if (n_dig >= 1) begin
            top1 = digs[n_dig - 1];
        end
        if (n_dig >= 2) begin
            top2 = digs[n_dig - 1] * 10 + digs[n_dig - 2];
        end
        res.brand_code = BRAND_NONE;
        // digits beyond the converter range void the brand
        if (rest == 0 && rem == 0) begin
            if (n_dig == 15 && (top2 == 34 || top2 == 37)) begin
                res.brand_code = BRAND_P34;
            end else if (n_dig == 16 && top2 >= 51 && top2 <= 55) begin
                res.brand_code = BRAND_P5X;
            end else if ((n_dig == 13 || n_dig == 16) && top1 == 4) begin
                res.brand_code = BRAND_P4;
            end
        end
        res.digit_count = n_dig[CNT_W-1:0];
        res.luhn_remainder = rem[3:0];
        res.luhn_ok = (rem == 0);
        return res;
    endfunction

    // number of len digits starting with pfx; the check digit per mode
    function automatic t_card card_build(input int unsigned pfx, input int unsigned pfx_len,
                                         input int unsigned len, input t_fill_mode mode);
        logic [63:0] num;
        t_result     res;
        num = pfx;
        for (int k = pfx_len; k < len - 1; k++) begin
            num = num * 10 + $urandom_range(9);
        end
        num = num * 10;
        if (mode == FILL_RANDOM) begin
            num += $urandom_range(9);
        end else begin
            res = luhn_classify(num[CARD_W-1:0]);
            num += (10 - res.luhn_remainder) % 10;
            // an odd-position step of one always breaks the checksum
            if (mode == FILL_BROKEN) begin
                num = (num % 10 == 9) ? num - 1 : num + 1;
            end
        end
        return num[CARD_W-1:0];
    endfunction

    function automatic t_card random_card();
        logic [63:0] wide;
        int unsigned sel;
        int unsigned len;
        int unsigned pfx;
        t_fill_mode  mode;
        sel = $urandom_range(99);
        mode = ($urandom_range(4) == 0) ? FILL_BROKEN : FILL_VALID;
        if (sel < 15) begin
            wide = {$urandom, $urandom};
            return wide[CARD_W-1:0];
        end else if (sel < 25) begin
            wide = $urandom_range(9999);
            return wide[CARD_W-1:0];
        end else if (sel < 45) begin
            // any length; leading digit kept below the 63-bit ceiling at 19
            len = $urandom_range(2, 19);
            pfx = $urandom_range(1, (len == 19) ? 8 : 9);
            return card_build(pfx, 1, len, $urandom_range(1) ? FILL_RANDOM : FILL_VALID);
        end
        // brand-shaped numbers, lengths mostly on target, sometimes one off
        case ($urandom_range(2))
            0: begin
                pfx = $urandom_range(1) ? ($urandom_range(1) ? 34 : 37) : $urandom_range(33, 38);
                len = ($urandom_range(3) == 0) ? $urandom_range(14, 16) : 15;
                return card_build(pfx, 2, len, mode);
            end
            1: begin
                pfx = $urandom_range(50, 56);
                len = ($urandom_range(3) == 0) ? $urandom_range(15, 17) : 16;
                return card_build(pfx, 2, len, mode);
            end
            default: begin
                pfx = ($urandom_range(3) == 0) ? $urandom_range(3, 5) : 4;
                len = ($urandom_range(3) == 0) ? $urandom_range(12, 17)
                                               : ($urandom_range(1) ? 13 : 16);
                return card_build(pfx, 1, len, mode);
            end
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // sender: hold an item until taken, then maybe idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (card_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {1'b0, card_q.pop_front()};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // predict accepted items, check returned items
    always @(posedge i_clk) begin
        t_luhn_expect exp_item;
        t_result      got;
        in_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            exp_item.card = i_s_axis_tdata[CARD_W-1:0];
            exp_item.res = luhn_classify(exp_item.card);
            luhn_exp_q.push_back(exp_item);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
            if (luhn_exp_q.size() == 0) begin
                $error("unexpected item: tdata 0x%0h", o_m_axis_tdata);
                err_cnt++;
            end else begin
                exp_item = luhn_exp_q.pop_front();
                if (got.brand_code != exp_item.res.brand_code) begin
                    $error("card %0d brand_code: expected %0d, got %0d", exp_item.card,
                           exp_item.res.brand_code, got.brand_code);
                    err_cnt++;
                end
                if (got.digit_count != exp_item.res.digit_count) begin
                    $error("card %0d digit_count: expected %0d, got %0d", exp_item.card,
                           exp_item.res.digit_count, got.digit_count);
                    err_cnt++;
                end
                if (got.luhn_remainder != exp_item.res.luhn_remainder) begin
                    $error("card %0d luhn_remainder: expected %0d, got %0d", exp_item.card,
                           exp_item.res.luhn_remainder, got.luhn_remainder);
                    err_cnt++;
                end
                if (got.luhn_ok != exp_item.res.luhn_ok) begin
                    $error("card %0d luhn_ok: expected %0d, got %0d", exp_item.card,
                           exp_item.res.luhn_ok, got.luhn_ok);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned idle_tab [NUM_PHASES];
        int unsigned stall_tab [NUM_PHASES];
        logic [63:0] wide;
        idle_tab = '{0, 56, 0, 19};
        stall_tab = '{0, 0, 56, 19};
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        in_taken = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        err_cnt = 0;
        cycle_cnt = 0;

        // directed: zero, short, extremes of width and length, brand edges
        card_q.push_back('0);
        card_q.push_back(t_card'(1));
        card_q.push_back(t_card'(9));
        card_q.push_back(t_card'(10));
        card_q.push_back(t_card'(99));
        card_q.push_back('1);
        wide = 64'd1000000000000000000;
        card_q.push_back(wide[CARD_W-1:0]);
        wide = 64'd999999999999999999;
        card_q.push_back(wide[CARD_W-1:0]);
        card_q.push_back(card_build(34, 2, 15, FILL_VALID));
        card_q.push_back(card_build(37, 2, 15, FILL_VALID));
        card_q.push_back(card_build(37, 2, 15, FILL_BROKEN));
        card_q.push_back(card_build(35, 2, 15, FILL_VALID));
        card_q.push_back(card_build(34, 2, 14, FILL_VALID));
        card_q.push_back(card_build(34, 2, 16, FILL_VALID));
        card_q.push_back(card_build(51, 2, 16, FILL_VALID));
        card_q.push_back(card_build(55, 2, 16, FILL_VALID));
        card_q.push_back(card_build(50, 2, 16, FILL_VALID));
        card_q.push_back(card_build(56, 2, 16, FILL_VALID));
        card_q.push_back(card_build(53, 2, 16, FILL_BROKEN));
        card_q.push_back(card_build(52, 2, 15, FILL_VALID));
        card_q.push_back(card_build(4, 1, 13, FILL_VALID));
        card_q.push_back(card_build(4, 1, 16, FILL_VALID));
        card_q.push_back(card_build(4, 1, 15, FILL_VALID));
        card_q.push_back(card_build(4, 1, 16, FILL_BROKEN));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // random items under each flow-control mix
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            while (card_q.size() != 0) begin
                @(posedge i_clk);
            end
            send_idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                card_q.push_back(random_card());
            end
        end

        while (card_q.size() != 0 || i_s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (luhn_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
